// File: rtl/core/hst_pkg.sv
// Shared constants, character codes and keyword tables for the markup-to-text block.
// No dependencies; imported by hst_tag_match, html_span_to_text and the checker.
package hst_pkg;

   localparam int TAG_BUF     = 7;
   localparam int NUM_ENT     = 7;
   localparam int NUM_BRK     = 12;
   localparam int MAX_RESULTS = 40;
   localparam int RES_CW      = $clog2(MAX_RESULTS + 1);
   localparam int ENT_NBSP    = 5;

   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_SP    = 8'h20;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      if (c >= 8'h41 && c <= 8'h5A) begin
         return c + 8'd32;
      end
      return c;
   endfunction

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SP) || (c == CH_TAB) || (c == CH_LF) || (c == CH_CR);
   endfunction

   function automatic logic is_delim(input logic [7:0] c);
      return (c == CH_GT) || (c == CH_SLASH) || is_ws(c);
   endfunction

   // break keywords, character j at bits [8j+7:8j]
   function automatic logic [39:0] brk_word(input logic [3:0] k);
      logic [39:0] w;
      case (k)
         4'd0:    w = {32'h0, "p"};
         4'd1:    w = {16'h0, "vid"};
         4'd2:    w = {24'h0, "rb"};
         4'd3:    w = {24'h0, "il"};
         4'd4:    w = {24'h0, "1h"};
         4'd5:    w = {24'h0, "2h"};
         4'd6:    w = {24'h0, "3h"};
         4'd7:    w = {24'h0, "4h"};
         4'd8:    w = {24'h0, "5h"};
         4'd9:    w = {24'h0, "6h"};
         4'd10:   w = {24'h0, "rt"};
         4'd11:   w = "elbat";
         default: w = 40'h0;
      endcase
      return w;
   endfunction

   function automatic int brk_len(input logic [3:0] k);
      int n;
      case (k)
         4'd0:    n = 1;
         4'd1:    n = 3;
         4'd11:   n = 5;
         default: n = 2;
      endcase
      return n;
   endfunction

   function automatic logic [47:0] ent_word(input logic [2:0] k);
      logic [47:0] w;
      case (k)
         3'd0:    w = {16'h0, ";tl&"};
         3'd1:    w = {16'h0, ";tg&"};
         3'd2:    w = ";touq&";
         3'd3:    w = {8'h0, ";93#&"};
         3'd4:    w = ";sopa&";
         3'd5:    w = ";psbn&";
         3'd6:    w = {8'h0, ";pma&"};
         default: w = 48'h0;
      endcase
      return w;
   endfunction

   function automatic logic [7:0] ent_char(input logic [2:0] k, input logic [3:0] pos);
      logic [47:0] w;
      w = ent_word(k) >> {pos, 3'b000};
      return w[7:0];
   endfunction

   function automatic logic [3:0] ent_len(input logic [2:0] k);
      logic [3:0] n;
      case (k)
         3'd0, 3'd1: n = 4'd4;
         3'd3, 3'd6: n = 4'd5;
         default:    n = 4'd6;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] ent_val(input logic [2:0] k);
      logic [7:0] v;
      case (k)
         3'd0:       v = CH_LT;
         3'd1:       v = CH_GT;
         3'd2:       v = 8'h22;
         3'd3, 3'd4: v = 8'h27;
         3'd5:       v = CH_SP;
         default:    v = CH_AMP;
      endcase
      return v;
   endfunction

endpackage

// File: rtl/core/hst_tag_match.sv
// Break-tag recognizer: checks a captured tag name against the break keywords.
// Depends on hst_pkg for the keyword table and character classes.
module hst_tag_match
   import hst_pkg::*;
(
   input  logic [TAG_BUF-1:0][7:0] tag_buf,
   input  logic [2:0]              tag_len,
   output logic                    hit
);

   logic [TAG_BUF-1:0][7:0] v;
   logic [2:0]              n;
   logic                    s;
   logic [1:0]              ok;
   logic [39:0]             w;
   int                      len_k;

   always_comb begin
      for (int i = 0; i < TAG_BUF; i++) begin
         if (3'(i) < tag_len) begin
            v[i] = to_lower(tag_buf[i]);
         end else if (3'(i) == tag_len) begin
            v[i] = CH_GT;
         end else begin
            v[i] = 8'h00;
         end
      end
      n = (tag_len == 3'(TAG_BUF)) ? tag_len : tag_len + 3'd1;
      s = (v[0] == CH_SLASH);
      hit = 1'b0;
      w = 40'h0;
      len_k = 0;
      ok = 2'b00;
      for (int k = 0; k < NUM_BRK; k++) begin
         w = brk_word(4'(k));
         len_k = brk_len(4'(k));
         for (int off = 0; off < 2; off++) begin
            ok[off] = (off + len_k) < int'(n);
            for (int j = 0; j < 5; j++) begin
               if (j < len_k && v[off + j] != w[8*j +: 8]) begin
                  ok[off] = 1'b0;
               end
            end
            if (!is_delim(v[off + len_k])) begin
               ok[off] = 1'b0;
            end
         end
         if (s ? ok[1] : ok[0]) begin
            hit = 1'b1;
         end
      end
   end

endmodule

// File: rtl/core/html_span_to_text.sv
// Markup span to rendered text converter, top level.
// Depends on hst_pkg and hst_tag_match.
//
// Input channel req_*: one transaction per markup byte (req_tuser = 0) or an
// end-of-span marker (req_tuser = 1). Result channel rsp_*: one transaction
// per rendered byte; rsp_tuser flags that rsp_tdata carries a byte, rsp_tlast
// marks the final result of an end-of-span marker (a span with no pending
// text yields one result with rsp_tuser = 0 and rsp_tlast = 1).
// A small sequencer handles one transaction at a time and takes no new one
// until it is done. A byte that only changes state is accepted and decoded;
// a separator that is held then passes the push step. A byte that emits
// passes the character step, which first flushes each held separator; a
// failed entity match replays each prefix byte and decodes the byte again.
// An end-of-span marker passes the final step, or flushes held separators
// and replays the prefix when a partial entity is pending. All output leaves
// through the single result register, one byte a cycle while the receiver
// is ready. When it stalls, the sequencer holds at the emitting step; a
// finished result may wait in the register while the next transaction is taken.
// Reset (synchronous, active high) empties the result register and returns
// the tag, entity and separator state to the start-of-span condition.
module html_span_to_text
   import hst_pkg::*;
#(
   parameter int PENDING_DEPTH = 32,
   parameter int ENTITY_MAX    = 6
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic       req_tuser,   // [0] kind
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic       rsp_tuser,   // [0] has_byte
   output logic       rsp_tlast
);

   localparam int PCW = $clog2(PENDING_DEPTH + 1);
   localparam int PIW = $clog2(PENDING_DEPTH);
   localparam int EW  = $clog2(ENTITY_MAX + 1);
   localparam int EIW = $clog2(ENTITY_MAX);

   typedef enum logic [2:0] {
      S_IDLE, S_DECIDE, S_PUSH, S_CHAR, S_REPLAY, S_LAST
   } state_type;

   state_type                  st_ff, st_in;
   logic                       kind_ff, kind_in;
   logic [7:0]                 byte_ff, byte_in;
   logic [7:0]                 char_ff, char_in;
   logic                       push_nl_ff, push_nl_in;
   logic                       in_tag_ff, in_tag_in;
   logic [TAG_BUF-1:0][7:0]    tag_buf_ff, tag_buf_in;
   logic [2:0]                 tag_len_ff, tag_len_in;
   logic [ENTITY_MAX-1:0][7:0] ent_buf_ff, ent_buf_in;
   logic [EW-1:0]              ent_len_ff, ent_len_in;
   logic [NUM_ENT-1:0]         ent_mask_ff, ent_mask_in;
   logic                       space_ff, space_in;
   logic [PENDING_DEPTH-1:0]   pend_ff, pend_in;
   logic [PCW-1:0]             pcnt_ff, pcnt_in;
   logic [EIW-1:0]             rep_idx_ff, rep_idx_in;
   logic [RES_CW-1:0]          res_cnt_ff, res_cnt_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [7:0]                 rsp_byte_ff, rsp_byte_in;
   logic                       rsp_has_ff, rsp_has_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic                       tag_hit;
   logic                       slot_ok, capped, go;
   logic                       emit_req, emit_has, emit_fin;
   logic [7:0]                 emit_byte;
   logic [7:0]                 sep_byte;
   logic [PCW-1:0]             pm1;
   logic [3:0]                 pos, nl;
   logic                       full_hit, room, rep_done;
   logic [2:0]                 full_k;
   logic [NUM_ENT-1:0]         pre_mask;

   hst_tag_match u_tag_match (
      .tag_buf (tag_buf_ff),
      .tag_len (tag_len_ff),
      .hit     (tag_hit)
   );

   assign req_tready = (st_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_byte_ff;
   assign rsp_tuser  = rsp_has_ff;
   assign rsp_tlast  = rsp_last_ff;

   always_comb begin
      st_in       = st_ff;
      kind_in     = kind_ff;
      byte_in     = byte_ff;
      char_in     = char_ff;
      push_nl_in  = push_nl_ff;
      in_tag_in   = in_tag_ff;
      tag_buf_in  = tag_buf_ff;
      tag_len_in  = tag_len_ff;
      ent_buf_in  = ent_buf_ff;
      ent_len_in  = ent_len_ff;
      ent_mask_in = ent_mask_ff;
      space_in    = space_ff;
      pend_in     = pend_ff;
      pcnt_in     = pcnt_ff;
      rep_idx_in  = rep_idx_ff;
      res_cnt_in  = res_cnt_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_has_in  = rsp_has_ff;
      rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;

      slot_ok   = !rsp_valid_ff || rsp_tready;
      capped    = (res_cnt_ff == RES_CW'(MAX_RESULTS));
      go        = slot_ok || capped;
      sep_byte  = pend_ff[0] ? CH_LF : CH_SP;
      pm1       = pcnt_ff - PCW'(1);
      emit_req  = 1'b0;
      emit_has  = 1'b1;
      emit_fin  = 1'b0;
      emit_byte = 8'h00;

      // entity candidate tracking: the mask holds entities still matching
      pos      = 4'(ent_len_ff);
      nl       = pos + 4'd1;
      room     = ent_len_ff < EW'(ENTITY_MAX);
      full_hit = 1'b0;
      full_k   = 3'd0;
      pre_mask = '0;
      for (int k = 0; k < NUM_ENT; k++) begin
         if (ent_mask_ff[k] && ent_char(3'(k), pos) == byte_ff) begin
            if (ent_len(3'(k)) == nl && !full_hit) begin
               full_hit = 1'b1;
               full_k   = 3'(k);
            end
            if (ent_len(3'(k)) > nl) begin
               pre_mask[k] = 1'b1;
            end
         end
      end
      rep_done = (EW'(rep_idx_ff) + EW'(1)) == ent_len_ff;

      case (st_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               kind_in    = req_tuser;
               byte_in    = req_tdata;
               res_cnt_in = '0;
               st_in      = S_DECIDE;
            end
         end
         S_DECIDE: begin
            st_in = S_IDLE;
            if (kind_ff) begin
               if (!in_tag_ff && ent_len_ff != '0) begin
                  rep_idx_in = '0;
                  st_in      = S_REPLAY;
               end else begin
                  st_in = S_LAST;
               end
            end else if (in_tag_ff) begin
               if (byte_ff == CH_GT) begin
                  in_tag_in = 1'b0;
                  if (tag_hit) begin
                     if (!space_ff) begin
                        push_nl_in = 1'b1;
                        space_in   = 1'b1;
                        st_in      = S_PUSH;
                     end else if (pcnt_ff != '0) begin
                        // promote the held trailing space to a newline
                        pend_in[pm1[PIW-1:0]] = 1'b1;
                     end
                  end
               end else if (tag_len_ff < 3'(TAG_BUF)) begin
                  tag_buf_in[tag_len_ff] = byte_ff;
                  tag_len_in = tag_len_ff + 3'd1;
               end
            end else if (ent_len_ff != '0) begin
               if (room && full_hit) begin
                  ent_len_in = '0;
                  if (full_k == 3'(ENT_NBSP)) begin
                     push_nl_in = 1'b0;
                     space_in   = 1'b0;
                     st_in      = S_PUSH;
                  end else begin
                     char_in  = ent_val(full_k);
                     space_in = 1'b0;
                     st_in    = S_CHAR;
                  end
               end else if (room && pre_mask != '0) begin
                  ent_buf_in[ent_len_ff[EIW-1:0]] = byte_ff;
                  ent_len_in  = ent_len_ff + EW'(1);
                  ent_mask_in = pre_mask;
               end else begin
                  // replay the prefix, then decode this byte again as plain text
                  rep_idx_in = '0;
                  space_in   = 1'b0;
                  st_in      = S_REPLAY;
               end
            end else if (byte_ff == CH_LT) begin
               in_tag_in  = 1'b1;
               tag_len_in = 3'd0;
            end else if (byte_ff == CH_AMP) begin
               ent_buf_in[0] = CH_AMP;
               ent_len_in    = EW'(1);
               ent_mask_in   = '1;
            end else if (is_ws(byte_ff)) begin
               if (!space_ff) begin
                  push_nl_in = 1'b0;
                  space_in   = 1'b1;
                  st_in      = S_PUSH;
               end
            end else begin
               char_in  = byte_ff;
               space_in = 1'b0;
               st_in    = S_CHAR;
            end
         end
         S_PUSH: begin
            if (pcnt_ff == PCW'(PENDING_DEPTH)) begin
               // run full: emit the oldest separator early
               emit_req  = 1'b1;
               emit_byte = sep_byte;
               if (go) begin
                  pend_in = pend_ff >> 1;
                  pend_in[PENDING_DEPTH-1] = push_nl_ff;
                  st_in = S_IDLE;
               end
            end else begin
               pend_in[pcnt_ff[PIW-1:0]] = push_nl_ff;
               pcnt_in = pcnt_ff + PCW'(1);
               st_in   = S_IDLE;
            end
         end
         S_CHAR: begin
            emit_req = 1'b1;
            if (pcnt_ff != '0) begin
               emit_byte = sep_byte;
               if (go) begin
                  pend_in = pend_ff >> 1;
                  pcnt_in = pm1;
               end
            end else begin
               emit_byte = char_ff;
               if (go) begin
                  st_in = S_IDLE;
               end
            end
         end
         S_REPLAY: begin
            emit_req = 1'b1;
            if (pcnt_ff != '0) begin
               emit_byte = sep_byte;
               if (go) begin
                  pend_in = pend_ff >> 1;
                  pcnt_in = pm1;
               end
            end else begin
               emit_byte = ent_buf_ff[rep_idx_ff];
               emit_fin  = rep_done;
               if (go) begin
                  if (rep_done) begin
                     ent_len_in = '0;
                     if (kind_ff) begin
                        in_tag_in  = 1'b0;
                        tag_len_in = 3'd0;
                        space_in   = 1'b1;
                        pcnt_in    = '0;
                        st_in      = S_IDLE;
                     end else begin
                        st_in = S_DECIDE;
                     end
                  end else begin
                     rep_idx_in = rep_idx_ff + EIW'(1);
                  end
               end
            end
         end
         S_LAST: begin
            emit_req  = 1'b1;
            emit_has  = 1'b0;
            emit_fin  = 1'b1;
            if (go) begin
               in_tag_in  = 1'b0;
               tag_len_in = 3'd0;
               ent_len_in = '0;
               space_in   = 1'b1;
               pcnt_in    = '0;
               st_in      = S_IDLE;
            end
         end
         default: begin
            st_in = S_IDLE;
         end
      endcase

      // results past the per-transaction limit are dropped
      if (emit_req && slot_ok && !capped) begin
         rsp_valid_in = 1'b1;
         rsp_byte_in  = emit_byte;
         rsp_has_in   = emit_has;
         rsp_last_in  = kind_ff &&
                        (emit_fin || res_cnt_ff == RES_CW'(MAX_RESULTS - 1));
         res_cnt_in   = res_cnt_ff + RES_CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= S_IDLE;
         in_tag_ff    <= 1'b0;
         tag_len_ff   <= 3'd0;
         ent_len_ff   <= '0;
         space_ff     <= 1'b1;
         pcnt_ff      <= '0;
         pend_ff      <= '0;
         res_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         in_tag_ff    <= in_tag_in;
         tag_len_ff   <= tag_len_in;
         ent_len_ff   <= ent_len_in;
         space_ff     <= space_in;
         pcnt_ff      <= pcnt_in;
         pend_ff      <= pend_in;
         res_cnt_ff   <= res_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      kind_ff     <= kind_in;
      byte_ff     <= byte_in;
      char_ff     <= char_in;
      push_nl_ff  <= push_nl_in;
      tag_buf_ff  <= tag_buf_in;
      ent_buf_ff  <= ent_buf_in;
      ent_mask_ff <= ent_mask_in;
      rep_idx_ff  <= rep_idx_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_has_ff  <= rsp_has_in;
      rsp_last_ff <= rsp_last_in;
   end

`ifndef SYNTH
   a_pend_bound: assert property (@(posedge clock) disable iff (reset)
      pcnt_ff <= PCW'(PENDING_DEPTH))
      else $error("separator run count out of range");

   a_tag_xor_ent: assert property (@(posedge clock) disable iff (reset)
      !(in_tag_ff && ent_len_ff != '0))
      else $error("tag and entity active together");

   a_blank_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_has_ff) |-> rsp_last_ff)
      else $error("empty result without end of span");

   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_LAST && go) |=> (pcnt_ff == '0 && space_ff && !in_tag_ff))
      else $error("span state not cleared after end of span");

   a_res_bound: assert property (@(posedge clock) disable iff (reset)
      res_cnt_ff <= RES_CW'(MAX_RESULTS))
      else $error("result count beyond limit");
`endif

endmodule

// File: dv/span_text_checker.sv
// Checker for html_span_to_text: watches both channels, predicts the rendered
// text from accepted markup transactions and compares results field by field.
// Depends on hst_pkg for character codes.
`timescale 1ns / 1ps
module span_text_checker
   import hst_pkg::*;
#(
   parameter int PENDING_DEPTH = 32,
   parameter int ENTITY_MAX    = 6
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   input  logic       req_tready,
   input  logic [7:0] req_tdata,
   input  logic       req_tuser,
   input  logic       rsp_tvalid,
   input  logic       rsp_tready,
   input  logic [7:0] rsp_tdata,
   input  logic       rsp_tuser,
   input  logic       rsp_tlast,
   output int         fail_count,
   output int         pending_results
);

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       last;
   } text_result_type;

   text_result_type text_q[$];

   // predictor state
   logic       m_in_tag;
   logic [7:0] m_tag_name[TAG_BUF];
   int         m_tag_len;
   logic [7:0] m_ent[ENTITY_MAX];
   int         m_ent_len;
   logic       m_space;
   logic       m_seps[PENDING_DEPTH];
   int         m_sep_cnt;
   int         m_emitted;

   function automatic string ent_text(int k);
      case (k)
         0: return "&lt;";
         1: return "&gt;";
         2: return "&quot;";
         3: return "&#39;";
         4: return "&apos;";
         5: return "&nbsp;";
         default: return "&amp;";
      endcase
   endfunction

   function automatic logic [7:0] ent_value(int k);
      case (k)
         0: return CH_LT;
         1: return CH_GT;
         2: return 8'h22;
         3, 4: return 8'h27;
         5: return CH_SP;
         default: return CH_AMP;
      endcase
   endfunction

   function automatic string brk_text(int k);
      case (k)
         0: return "p";
         1: return "div";
         2: return "br";
         3: return "li";
         4: return "h1";
         5: return "h2";
         6: return "h3";
         7: return "h4";
         8: return "h5";
         9: return "h6";
         10: return "tr";
         default: return "table";
      endcase
   endfunction

   function automatic logic white(logic [7:0] c);
      return c == CH_SP || c == CH_TAB || c == CH_LF || c == CH_CR;
   endfunction

   function automatic logic [7:0] fold(logic [7:0] c);
      return (c >= 8'h41 && c <= 8'h5A) ? c + 8'd32 : c;
   endfunction

   task automatic clear_state();
      m_in_tag = 0;
      m_tag_len = 0;
      m_ent_len = 0;
      m_space = 1;
      m_sep_cnt = 0;
      for (int i = 0; i < PENDING_DEPTH; i++) m_seps[i] = 0;
   endtask

   task automatic push_text(logic [7:0] b, logic hb, logic lst);
      text_result_type r;
      r.out_byte = b;
      r.has_byte = hb;
      r.last = lst;
      if (m_emitted < MAX_RESULTS) begin
         text_q.push_back(r);
         m_emitted++;
      end
   endtask

   function automatic logic [7:0] sep_char(logic nl);
      return nl ? CH_LF : CH_SP;
   endfunction

   task automatic hold_sep(logic nl);
      if (m_sep_cnt >= PENDING_DEPTH) begin
         push_text(sep_char(m_seps[0]), 1, 0);
         for (int i = 0; i < PENDING_DEPTH - 1; i++) m_seps[i] = m_seps[i + 1];
         m_sep_cnt = PENDING_DEPTH - 1;
      end
      m_seps[m_sep_cnt] = nl;
      m_sep_cnt++;
   endtask

   task automatic print_char(logic [7:0] c);
      for (int i = 0; i < m_sep_cnt; i++) push_text(sep_char(m_seps[i]), 1, 0);
      m_sep_cnt = 0;
      push_text(c, 1, 0);
      m_space = 0;
   endtask

   task automatic close_tag();
      logic [7:0] v[TAG_BUF + 1];
      int n, s, len;
      logic ok;
      string w;
      n = m_tag_len;
      for (int i = 0; i < n; i++) v[i] = m_tag_name[i];
      if (n < TAG_BUF) begin
         v[n] = CH_GT;
         n++;
      end
      s = (n > 0 && v[0] == CH_SLASH) ? 1 : 0;
      for (int k = 0; k < 12; k++) begin
         w = brk_text(k);
         len = w.len();
         ok = (s + len) < n;
         for (int j = 0; ok && j < len; j++)
            if (fold(v[s + j]) != w[j]) ok = 0;
         if (ok && (white(v[s + len]) || v[s + len] == CH_GT
                    || v[s + len] == CH_SLASH)) begin
            if (!m_space) begin
               hold_sep(1);
               m_space = 1;
            end else if (m_sep_cnt > 0 && m_seps[m_sep_cnt - 1] == 0) begin
               m_seps[m_sep_cnt - 1] = 1;
            end
            return;
         end
      end
   endtask

   task automatic text_byte(logic [7:0] c);
      if (c == CH_LT) begin
         m_in_tag = 1;
         m_tag_len = 0;
      end else if (c == CH_AMP) begin
         m_ent[0] = CH_AMP;
         m_ent_len = 1;
      end else if (white(c)) begin
         if (!m_space) begin
            hold_sep(0);
            m_space = 1;
         end
      end else begin
         print_char(c);
      end
   endtask

   task automatic replay_prefix();
      for (int i = 0; i < m_ent_len; i++) print_char(m_ent[i]);
      m_ent_len = 0;
   endtask

   task automatic entity_char(logic [7:0] c);
      logic prefix;
      logic same;
      int nl;
      string e;
      prefix = 0;
      if (m_ent_len < ENTITY_MAX) begin
         m_ent[m_ent_len] = c;
         nl = m_ent_len + 1;
         for (int k = 0; k < 7; k++) begin
            e = ent_text(k);
            same = e.len() >= nl;
            for (int j = 0; same && j < nl; j++)
               if (e[j] != m_ent[j]) same = 0;
            if (same) begin
               if (e.len() == nl) begin
                  m_ent_len = 0;
                  if (ent_value(k) == CH_SP) begin
                     hold_sep(0);
                     m_space = 0;
                  end else begin
                     print_char(ent_value(k));
                  end
                  return;
               end
               prefix = 1;
            end
         end
         if (prefix) begin
            m_ent_len = nl;
            return;
         end
      end
      replay_prefix();
      text_byte(c);
   endtask

   task automatic predict_item(logic span_end, logic [7:0] c);
      m_emitted = 0;
      if (span_end) begin
         if (!m_in_tag) replay_prefix();
         if (m_emitted == 0) push_text(8'h00, 0, 1);
         else text_q[$].last = 1;
         clear_state();
      end else if (m_in_tag) begin
         if (c == CH_GT) begin
            close_tag();
            m_in_tag = 0;
         end else if (m_tag_len < TAG_BUF) begin
            m_tag_name[m_tag_len] = c;
            m_tag_len++;
         end
      end else if (m_ent_len > 0) begin
         entity_char(c);
      end else begin
         text_byte(c);
      end
   endtask

   always @(posedge clock) begin
      text_result_type want;
      int errs;
      errs = 0;
      if (reset) begin
         clear_state();
         text_q.delete();
         fail_count <= 0;
         pending_results <= 0;
      end else begin
         // compare before predicting: a result cannot come from this same edge's input
         if (rsp_tvalid && rsp_tready) begin
            if (text_q.size() == 0) begin
               $error("unexpected result: out_byte=%h has_byte=%b last=%b",
                      rsp_tdata, rsp_tuser, rsp_tlast);
               errs++;
            end else begin
               want = text_q.pop_front();
               if (rsp_tdata !== want.out_byte) begin
                  $error("out_byte expected %h actual %h", want.out_byte, rsp_tdata);
                  errs++;
               end
               if (rsp_tuser !== want.has_byte) begin
                  $error("has_byte expected %b actual %b", want.has_byte, rsp_tuser);
                  errs++;
               end
               if (rsp_tlast !== want.last) begin
                  $error("last expected %b actual %b", want.last, rsp_tlast);
                  errs++;
               end
            end
         end
         if (req_tvalid && req_tready) predict_item(req_tuser, req_tdata);
         fail_count <= fail_count + errs;
         pending_results <= text_q.size();
      end
   end

endmodule

// File: dv/testbench.sv
// Top of the html_span_to_text testbench: clock, reset, stimulus and verdict.
// Depends on html_span_to_text and span_text_checker.
`timescale 1ns / 1ps
module testbench;

   logic       clock = 0;
   logic       reset = 1;
   logic       req_tvalid = 0;
   logic       req_tready;
   logic [7:0] req_tdata = 0;
   logic       req_tuser = 0;
   logic       rsp_tvalid;
   logic       rsp_tready = 0;
   logic [7:0] rsp_tdata;
   logic       rsp_tuser;
   logic       rsp_tlast;
   int         fail_count;
   int         pending_results;
   logic       calm = 0;
   logic       hold_off = 0;

   logic [8:0] markup_q[$];

   always #5 clock = ~clock;

   html_span_to_text dut (.*);

   span_text_checker checker_i (.*);

   // receiver: random stalls, none while calm, stalled throughout hold-off
   always @(posedge clock) begin
      if (reset || hold_off) rsp_tready <= 0;
      else rsp_tready <= calm || ($urandom_range(99) >= 10);
   end

   task automatic add_text(string s);
      for (int i = 0; i < s.len(); i++) markup_q.push_back({1'b0, s[i]});
   endtask

   task automatic add_end();
      markup_q.push_back({1'b1, 8'h00});
   endtask

   function automatic string rand_piece();
      case ($urandom_range(15))
         0: return "<p>";
         1: return "</DIV>";
         2: return "<br/>";
         3: return "<Li class=x>";
         4: return $sformatf("<h%0d>", $urandom_range(0, 7));
         5: return "<TR>";
         6: return "<table ";
         7: return "&lt;";
         8: return "&gt;";
         9: return "&quot;";
         10: return "&#39;";
         11: return "&apos;";
         12: return "&nbsp;";
         13: return "&amp;";
         14: return "&qu";
         default: return "<span>";
      endcase
   endfunction

   task automatic send_all();
      logic [8:0] it;
      while (markup_q.size() > 0) begin
         it = markup_q.pop_front();
         req_tvalid <= calm || ($urandom_range(99) >= 10);
         req_tuser <= it[8];
         req_tdata <= it[7:0];
         @(posedge clock);
         while (!(req_tvalid && req_tready)) begin
            req_tvalid <= 1;
            @(posedge clock);
         end
      end
      req_tvalid <= 0;
   endtask

   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int n;
      logic [7:0] b;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: extremes, every entity and several tags, special cases
      add_end();
      add_text(" \t<P>A  b\n&lt;&gt;&quot;&#39;&apos;&amp;x&nbsp;");
      add_end();
      add_text("hi <br>");
      add_text("z");
      markup_q.push_back({1'b0, 8'h00});
      markup_q.push_back({1'b0, 8'hFF});
      add_text("<Table>q</tr><h7>&am");
      add_end();
      add_text("a<divXYZlong>b<unterminated");
      add_end();
      send_all();
      // long separator run overflows while the receiver holds off
      hold_off <= 1;
      add_text("x");
      for (int i = 0; i < 18; i++) add_text("&nbsp; ");
      add_text("<br>y");
      add_end();
      fork
         send_all();
         begin
            repeat (300) @(posedge clock);
            hold_off <= 0;
         end
      join
      // random: mostly well-formed text with tags and entities
      n = 0;
      while (n < 45) begin
         calm <= (n >= 10 && n < 35);
         case ($urandom_range(9))
            0, 1, 2: begin
               b = $urandom_range(0, 3) == 0 ? 8'h20 : 8'($urandom_range(8'h61, 8'h7A));
               markup_q.push_back({1'b0, b});
            end
            3, 4: add_text(rand_piece());
            5: markup_q.push_back({1'b0, 8'($urandom)});
            6: markup_q.push_back({1'b1, 8'($urandom)});
            default: add_text("ab ");
         endcase
         n += markup_q.size();
         send_all();
      end
      calm <= 0;
      add_end();
      send_all();
      @(posedge clock);
      while (pending_results > 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (fail_count == 0 && pending_results == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
